>>> design/gaps_pkg.sv
package gaps_pkg;

  // result status codes
  typedef enum logic [2:0] {
    ST_PATH    = 3'd0,
    ST_RANGE   = 3'd1,
    ST_BLOCKED = 3'd2,
    ST_THERE   = 3'd3,
    ST_NOPATH  = 3'd4
  } status_t;

  // move directions, also used as the stored direction back to the parent
  typedef enum logic [1:0] {
    DIR_N = 2'd0,
    DIR_S = 2'd1,
    DIR_E = 2'd2,
    DIR_W = 2'd3
  } dir_t;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  // register select, taken from paddr[2]
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef struct packed {
    logic       func;
    logic [2:0] cell_row;
    logic [2:0] cell_col;
    logic       passable;
    logic [2:0] dst_row;
    logic [2:0] dst_col;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic [2:0] path_row;
    logic [2:0] path_col;
    logic       last;
  } out_item_t;

  // per-cell search record
  typedef struct packed {
    logic [14:0] f;
    logic [5:0]  g;
    dir_t        pdir;
  } node_t;

  // neighbor candidate handed from the neighbor unit to the sequencer
  typedef struct packed {
    logic        ok;
    logic        is_dst;
    logic [2:0]  row;
    logic [2:0]  col;
    dir_t        back;
    logic [14:0] f;
    logic [5:0]  g;
  } nbr_t;

  // floor(256 * sqrt(dy*dy + dx*dx)), indexed by {dy, dx}
  typedef logic [11:0] heur_tab_t [64];

  function automatic heur_tab_t heur_tab_f();
    heur_tab_t   tab;
    logic [31:0] s;
    logic [31:0] res;
    logic [31:0] bit_v;
    for (int dy = 0; dy < 8; dy++) begin
      for (int dx = 0; dx < 8; dx++) begin
        s     = 32'((dy * dy + dx * dx) << 16);
        res   = '0;
        bit_v = 32'h4000_0000;
        for (int i = 0; i < 16; i++) begin
          if (s >= res + bit_v) begin
            s   = s - (res + bit_v);
            res = (res >> 1) + bit_v;
          end else begin
            res = res >> 1;
          end
          bit_v = bit_v >> 2;
        end
        tab[dy * 8 + dx] = res[11:0];
      end
    end
    return tab;
  endfunction

  localparam heur_tab_t HEUR_TAB = heur_tab_f();

endpackage

>>> design/grid_astar_path_search_top.sv
// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_ready   | in_item_t (cell write or search)
// out_    | output    | out_valid/out_ready | out_item_t (status, path cell, last)
// cfg     | input     | APB psel/penable    | grid_rows @0, grid_cols @4
//
// A cell write is applied in S_IDLE. A search holds in_ready low until its last item
// has been loaded into the output register: each expansion scans rows*cols
// cells through the one read port of the node memory, then tries the four
// neighbors in turn; the path walk reads and then steps each cell, and emission
// reads the path buffer before loading each item.
// Reset is synchronous; no clearing pass. out_ready low with out_valid high holds S_ERR/S_EMIT_OUT.
module grid_astar_path_search_top import gaps_pkg::*; #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NCELLS = MAX_ROWS * MAX_COLS;
  localparam int CW     = $clog2(NCELLS);
  localparam int NW     = $clog2(NCELLS + 1);
  localparam logic [3:0] ROWS_MAX = 4'(MAX_ROWS);
  localparam logic [3:0] COLS_MAX = 4'(MAX_COLS);

  typedef enum logic [12:0] {
    S_IDLE      = 13'b0000000000001,
    S_CHECK     = 13'b0000000000010,
    S_ERR       = 13'b0000000000100,
    S_SCAN      = 13'b0000000001000,
    S_SCAN_LAST = 13'b0000000010000,
    S_SCAN_DONE = 13'b0000000100000,
    S_EXP       = 13'b0000001000000,
    S_EXP_UPD   = 13'b0000010000000,
    S_WALK_REQ  = 13'b0000100000000,
    S_WALK_STEP = 13'b0001000000000,
    S_WALK_END  = 13'b0010000000000,
    S_EMIT_REQ  = 13'b0100000000000,
    S_EMIT_OUT  = 13'b1000000000000
  } state_t;

  function automatic logic [CW-1:0] idx_f(input logic [2:0] r, input logic [2:0] c);
    return CW'(int'(r) * MAX_COLS + int'(c));
  endfunction

  state_t             state_r, state_nxt;
  logic [3:0]         rows_r, rows_nxt, cols_r, cols_nxt;
  logic [NCELLS-1:0]  open_r, open_nxt;
  logic [NCELLS-1:0]  reached_r, reached_nxt;
  logic [NCELLS-1:0]  closed_r, closed_nxt;
  logic [2:0]         src_row_r, src_row_nxt, src_col_r, src_col_nxt;
  logic [2:0]         dst_row_r, dst_row_nxt, dst_col_r, dst_col_nxt;
  status_t            err_r, err_nxt;
  logic [2:0]         scan_row_r, scan_row_nxt, scan_col_r, scan_col_nxt;
  logic               p_valid_r, p_valid_nxt;
  logic [2:0]         p_row_r, p_row_nxt, p_col_r, p_col_nxt;
  logic               best_found_r, best_found_nxt;
  logic [14:0]        best_f_r, best_f_nxt;
  logic [5:0]         best_g_r, best_g_nxt;
  logic [2:0]         best_row_r, best_row_nxt, best_col_r, best_col_nxt;
  dir_t               dir_r, dir_nxt;
  nbr_t               nbr_r, nbr_nxt;
  logic [2:0]         cur_row_r, cur_row_nxt, cur_col_r, cur_col_nxt;
  logic [NW-1:0]      n_r, n_nxt, k_r, k_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  // node memory and path buffer
  node_t              node_mem [NCELLS];
  node_t              rd_node_r;
  logic [5:0]         pbuf_mem [NCELLS];
  logic [5:0]         pbuf_rd_r;

  logic               nm_we;
  logic [CW-1:0]      nm_waddr, nm_raddr;
  node_t              nm_wdata;
  logic               pb_we;
  logic [CW-1:0]      pb_waddr, pb_raddr;
  logic [5:0]         pb_wdata;

  logic [3:0]         rows_lim, cols_lim;
  logic               out_free;
  nbr_t               nbr;
  logic [CW-1:0]      src_idx, dst_idx, in_idx, scan_idx, nbr_idx, upd_idx, cur_idx;
  logic               scan_end, walk_brk;
  logic [3:0]         wr_nr, wr_nc;
  logic               cfg_wr;

  assign rows_lim = (rows_r > ROWS_MAX) ? ROWS_MAX : rows_r;
  assign cols_lim = (cols_r > COLS_MAX) ? COLS_MAX : cols_r;
  assign out_free = !out_valid_r || out_ready;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_COLS) ? {28'd0, cols_r} : {28'd0, rows_r};
  assign cfg_wr    = psel && penable && pwrite;

  assign src_idx  = idx_f(src_row_r, src_col_r);
  assign dst_idx  = idx_f(dst_row_r, dst_col_r);
  assign in_idx   = idx_f(in_data.cell_row, in_data.cell_col);
  assign scan_idx = idx_f(scan_row_r, scan_col_r);
  assign nbr_idx  = idx_f(nbr.row, nbr.col);
  assign upd_idx  = idx_f(nbr_r.row, nbr_r.col);
  assign cur_idx  = idx_f(cur_row_r, cur_col_r);
  assign scan_end = ({1'b0, scan_row_r} + 4'd1 == rows_lim) &&
                    ({1'b0, scan_col_r} + 4'd1 == cols_lim);

  gaps_nbr u_nbr (
    .dir      (dir_r),
    .best_row (best_row_r),
    .best_col (best_col_r),
    .best_g   (best_g_r),
    .dst_row  (dst_row_r),
    .dst_col  (dst_col_r),
    .rows_lim (rows_lim),
    .cols_lim (cols_lim),
    .nbr      (nbr)
  );

  // next step of the path walk from the stored parent direction
  always_comb begin
    wr_nr    = {1'b0, cur_row_r};
    wr_nc    = {1'b0, cur_col_r};
    walk_brk = 1'b0;
    unique case (rd_node_r.pdir)
      DIR_N: begin
        walk_brk = (cur_row_r == 3'd0);
        wr_nr    = {1'b0, cur_row_r} - 4'd1;
      end
      DIR_S: wr_nr = {1'b0, cur_row_r} + 4'd1;
      DIR_E: wr_nc = {1'b0, cur_col_r} + 4'd1;
      DIR_W: begin
        walk_brk = (cur_col_r == 3'd0);
        wr_nc    = {1'b0, cur_col_r} - 4'd1;
      end
      default: walk_brk = 1'b1;
    endcase
    if (wr_nr >= ROWS_MAX || wr_nc >= COLS_MAX) begin
      walk_brk = 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    rows_nxt       = rows_r;
    cols_nxt       = cols_r;
    open_nxt       = open_r;
    reached_nxt    = reached_r;
    closed_nxt     = closed_r;
    src_row_nxt    = src_row_r;
    src_col_nxt    = src_col_r;
    dst_row_nxt    = dst_row_r;
    dst_col_nxt    = dst_col_r;
    err_nxt        = err_r;
    scan_row_nxt   = scan_row_r;
    scan_col_nxt   = scan_col_r;
    p_valid_nxt    = 1'b0;
    p_row_nxt      = p_row_r;
    p_col_nxt      = p_col_r;
    best_found_nxt = best_found_r;
    best_f_nxt     = best_f_r;
    best_g_nxt     = best_g_r;
    best_row_nxt   = best_row_r;
    best_col_nxt   = best_col_r;
    dir_nxt        = dir_r;
    nbr_nxt        = nbr_r;
    cur_row_nxt    = cur_row_r;
    cur_col_nxt    = cur_col_r;
    n_nxt          = n_r;
    k_nxt          = k_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    nm_we          = 1'b0;
    nm_waddr       = upd_idx;
    nm_wdata       = '{f: nbr_r.f, g: nbr_r.g, pdir: nbr_r.back};
    nm_raddr       = scan_idx;
    pb_we          = 1'b0;
    pb_waddr       = n_r[CW-1:0];
    pb_wdata       = {cur_row_r, cur_col_r};
    pb_raddr       = CW'(n_r - NW'(1) - k_r);

    // configuration writes
    if (cfg_wr) begin
      if (paddr[2] == REG_COLS) begin
        cols_nxt = pwdata[3:0];
      end else begin
        rows_nxt = pwdata[3:0];
      end
    end

    // fold the returning scan item into the running minimum
    if ((state_r == S_SCAN || state_r == S_SCAN_LAST) && p_valid_r &&
        (!best_found_r || rd_node_r.f < best_f_r)) begin
      best_found_nxt = 1'b1;
      best_f_nxt     = rd_node_r.f;
      best_g_nxt     = rd_node_r.g;
      best_row_nxt   = p_row_r;
      best_col_nxt   = p_col_r;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.func == FUNC_WRITE) begin
            if ({1'b0, in_data.cell_row} < ROWS_MAX && {1'b0, in_data.cell_col} < COLS_MAX) begin
              open_nxt[in_idx] = in_data.passable;
            end
          end else begin
            src_row_nxt = in_data.cell_row;
            src_col_nxt = in_data.cell_col;
            dst_row_nxt = in_data.dst_row;
            dst_col_nxt = in_data.dst_col;
            state_nxt   = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (!({1'b0, src_row_r} < rows_lim && {1'b0, src_col_r} < cols_lim &&
              {1'b0, dst_row_r} < rows_lim && {1'b0, dst_col_r} < cols_lim)) begin
          err_nxt   = ST_RANGE;
          state_nxt = S_ERR;
        end else if (!open_r[src_idx] || !open_r[dst_idx]) begin
          err_nxt   = ST_BLOCKED;
          state_nxt = S_ERR;
        end else if (src_row_r == dst_row_r && src_col_r == dst_col_r) begin
          err_nxt   = ST_THERE;
          state_nxt = S_ERR;
        end else begin
          // open the search at the source
          reached_nxt          = '0;
          reached_nxt[src_idx] = 1'b1;
          closed_nxt           = '0;
          nm_we                = 1'b1;
          nm_waddr             = src_idx;
          nm_wdata             = '{f: '0, g: '0, pdir: DIR_N};
          scan_row_nxt         = '0;
          scan_col_nxt         = '0;
          best_found_nxt       = 1'b0;
          state_nxt            = S_SCAN;
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: err_r, path_row: '0, path_col: '0, last: 1'b1};
          state_nxt     = S_IDLE;
        end
      end
      S_SCAN: begin
        // issue one cell per cycle in row-major order
        nm_raddr    = scan_idx;
        p_valid_nxt = reached_r[scan_idx] && !closed_r[scan_idx];
        p_row_nxt   = scan_row_r;
        p_col_nxt   = scan_col_r;
        if (scan_end) begin
          state_nxt = S_SCAN_LAST;
        end else if ({1'b0, scan_col_r} + 4'd1 == cols_lim) begin
          scan_col_nxt = '0;
          scan_row_nxt = scan_row_r + 3'd1;
        end else begin
          scan_col_nxt = scan_col_r + 3'd1;
        end
      end
      S_SCAN_LAST: begin
        state_nxt = S_SCAN_DONE;
      end
      S_SCAN_DONE: begin
        if (!best_found_r) begin
          err_nxt   = ST_NOPATH;
          state_nxt = S_ERR;
        end else begin
          closed_nxt[idx_f(best_row_r, best_col_r)] = 1'b1;
          dir_nxt   = DIR_N;
          state_nxt = S_EXP;
        end
      end
      S_EXP: begin
        nm_raddr = nbr_idx;
        nbr_nxt  = nbr;
        if (nbr.ok && nbr.is_dst) begin
          // record the last link and start the walk back
          nm_we       = 1'b1;
          nm_waddr    = nbr_idx;
          nm_wdata    = '{f: nbr.f, g: nbr.g, pdir: nbr.back};
          cur_row_nxt = dst_row_r;
          cur_col_nxt = dst_col_r;
          n_nxt       = '0;
          state_nxt   = S_WALK_REQ;
        end else if (nbr.ok && !closed_r[nbr_idx] && open_r[nbr_idx]) begin
          state_nxt = S_EXP_UPD;
        end else if (dir_r == DIR_W) begin
          scan_row_nxt   = '0;
          scan_col_nxt   = '0;
          best_found_nxt = 1'b0;
          state_nxt      = S_SCAN;
        end else begin
          dir_nxt = dir_t'(dir_r + 2'd1);
        end
      end
      S_EXP_UPD: begin
        if (!reached_r[upd_idx] || rd_node_r.f > nbr_r.f) begin
          nm_we                = 1'b1;
          reached_nxt[upd_idx] = 1'b1;
        end
        if (dir_r == DIR_W) begin
          scan_row_nxt   = '0;
          scan_col_nxt   = '0;
          best_found_nxt = 1'b0;
          state_nxt      = S_SCAN;
        end else begin
          dir_nxt   = dir_t'(dir_r + 2'd1);
          state_nxt = S_EXP;
        end
      end
      S_WALK_REQ: begin
        if ((cur_row_r == src_row_r && cur_col_r == src_col_r) ||
            n_r == NW'(NCELLS - 1)) begin
          state_nxt = S_WALK_END;
        end else begin
          nm_raddr  = cur_idx;
          pb_we     = 1'b1;
          n_nxt     = n_r + NW'(1);
          state_nxt = S_WALK_STEP;
        end
      end
      S_WALK_STEP: begin
        if (walk_brk) begin
          state_nxt = S_WALK_END;
        end else begin
          cur_row_nxt = wr_nr[2:0];
          cur_col_nxt = wr_nc[2:0];
          state_nxt   = S_WALK_REQ;
        end
      end
      S_WALK_END: begin
        pb_we     = 1'b1;
        pb_wdata  = {src_row_r, src_col_r};
        n_nxt     = n_r + NW'(1);
        k_nxt     = '0;
        state_nxt = S_EMIT_REQ;
      end
      S_EMIT_REQ: begin
        state_nxt = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: ST_PATH, path_row: pbuf_rd_r[5:3],
                            path_col: pbuf_rd_r[2:0], last: (k_r == n_r - NW'(1))};
          if (k_r == n_r - NW'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + NW'(1);
            state_nxt = S_EMIT_REQ;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rows_r       <= 4'd8;
      cols_r       <= 4'd8;
      open_r       <= '0;
      reached_r    <= '0;
      closed_r     <= '0;
      p_valid_r    <= 1'b0;
      best_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
      n_r          <= '0;
      k_r          <= '0;
    end else begin
      state_r      <= state_nxt;
      rows_r       <= rows_nxt;
      cols_r       <= cols_nxt;
      open_r       <= open_nxt;
      reached_r    <= reached_nxt;
      closed_r     <= closed_nxt;
      p_valid_r    <= p_valid_nxt;
      best_found_r <= best_found_nxt;
      out_valid_r  <= out_valid_nxt;
      n_r          <= n_nxt;
      k_r          <= k_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    src_row_r  <= src_row_nxt;
    src_col_r  <= src_col_nxt;
    dst_row_r  <= dst_row_nxt;
    dst_col_r  <= dst_col_nxt;
    err_r      <= err_nxt;
    scan_row_r <= scan_row_nxt;
    scan_col_r <= scan_col_nxt;
    p_row_r    <= p_row_nxt;
    p_col_r    <= p_col_nxt;
    best_f_r   <= best_f_nxt;
    best_g_r   <= best_g_nxt;
    best_row_r <= best_row_nxt;
    best_col_r <= best_col_nxt;
    dir_r      <= dir_nxt;
    nbr_r      <= nbr_nxt;
    cur_row_r  <= cur_row_nxt;
    cur_col_r  <= cur_col_nxt;
    out_data_r <= out_data_nxt;
  end

  // node memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (nm_we) begin
      node_mem[nm_waddr] <= nm_wdata;
    end
    rd_node_r <= node_mem[nm_raddr];
  end

  // path buffer
  always_ff @(posedge clk) begin
    if (pb_we) begin
      pbuf_mem[pb_waddr] <= pb_wdata;
    end
    pbuf_rd_r <= pbuf_mem[pb_raddr];
  end

`ifndef SYNTHESIS
  // a closed cell has always been reached
  a_closed_reached: assert property (@(posedge clk) disable iff (!rst_n)
    (closed_r & ~reached_r) == '0)
    else $error("closed cell not reached");

  // a search item moves the sequencer to the checks
  a_search_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.func == FUNC_SEARCH |=> state_r == S_CHECK)
    else $error("search item not started");

  // the node memory is not written while the scan reads it
  a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_SCAN_LAST) |-> !nm_we)
    else $error("node write during scan");

  // the walk never overruns the path buffer
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= NW'(NCELLS))
    else $error("path buffer overrun");

  // the last emitted item returns the block to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT_OUT && out_free && k_r == n_r - NW'(1) |=> state_r == S_IDLE)
    else $error("no return to idle after last item");
`endif

endmodule

>>> design/gaps_nbr.sv
module gaps_nbr import gaps_pkg::*; (
  input  dir_t       dir,
  input  logic [2:0] best_row,
  input  logic [2:0] best_col,
  input  logic [5:0] best_g,
  input  logic [2:0] dst_row,
  input  logic [2:0] dst_col,
  input  logic [3:0] rows_lim,
  input  logic [3:0] cols_lim,
  output nbr_t       nbr
);

  logic [3:0]  nr;
  logic [3:0]  nc;
  logic [2:0]  dy;
  logic [2:0]  dx;
  logic [5:0]  g_new;

  always_comb begin
    // step from the expanded cell and check the grid edge
    nr       = {1'b0, best_row};
    nc       = {1'b0, best_col};
    nbr.ok   = 1'b0;
    nbr.back = DIR_S;
    unique case (dir)
      DIR_N: begin
        nbr.ok   = (best_row != 3'd0);
        nr       = {1'b0, best_row} - 4'd1;
        nbr.back = DIR_S;
      end
      DIR_S: begin
        nr       = {1'b0, best_row} + 4'd1;
        nbr.ok   = (nr < rows_lim);
        nbr.back = DIR_N;
      end
      DIR_E: begin
        nc       = {1'b0, best_col} + 4'd1;
        nbr.ok   = (nc < cols_lim);
        nbr.back = DIR_W;
      end
      DIR_W: begin
        nbr.ok   = (best_col != 3'd0);
        nc       = {1'b0, best_col} - 4'd1;
        nbr.back = DIR_E;
      end
      default: begin
        nbr.ok = 1'b0;
      end
    endcase

    // cost of reaching the neighbor through the expanded cell
    dy         = (nr[2:0] > dst_row) ? nr[2:0] - dst_row : dst_row - nr[2:0];
    dx         = (nc[2:0] > dst_col) ? nc[2:0] - dst_col : dst_col - nc[2:0];
    g_new      = best_g + 6'd1;
    nbr.row    = nr[2:0];
    nbr.col    = nc[2:0];
    nbr.is_dst = (nr[2:0] == dst_row) && (nc[2:0] == dst_col);
    nbr.g      = g_new;
    nbr.f      = 15'({g_new, 8'h00}) + 15'(HEUR_TAB[{dy, dx}]);
  end

endmodule

>>> tb/grid_astar_path_search_top_tb.sv
`timescale 1ns / 1ps

module grid_astar_path_search_top_tb;
  import gaps_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  grid_astar_path_search_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic [3:0]  grid_rows_q;
  logic [3:0]  grid_cols_q;
  logic        cell_open [64];
  logic        cell_closed [64];
  logic        cell_reached [64];
  logic [14:0] cell_f [64];
  logic [5:0]  cell_g [64];
  dir_t        cell_back [64];

  out_item_t   path_expect_q [$];
  int          mismatch_cnt;
  int          recv_cnt;
  bit          no_idle;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // floor(256 * sqrt(dy^2 + dx^2)) by binary search
  function automatic logic [11:0] dist_q8(int dy, int dx);
    longint s;
    longint lo;
    longint hi;
    longint mid;
    s  = longint'(dy * dy + dx * dx) << 16;
    lo = 0;
    hi = 4096;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (mid * mid <= s) lo = mid;
      else hi = mid;
    end
    return lo[11:0];
  endfunction

  function automatic dir_t flip_dir(dir_t d);
    case (d)
      DIR_N:   return DIR_S;
      DIR_S:   return DIR_N;
      DIR_E:   return DIR_W;
      default: return DIR_E;
    endcase
  endfunction

  function automatic void push_status(status_t s);
    out_item_t o;
    o.status   = s;
    o.path_row = '0;
    o.path_col = '0;
    o.last     = 1'b1;
    path_expect_q.push_back(o);
  endfunction

  // work out the results of one accepted item
  function automatic void astar_predict(in_item_t it);
    int        rows_used;
    int        cols_used;
    int        sr, sc, dr, dc, si, best, br, bc, nr, nc, nk, n, r, c, k;
    logic [5:0]  gnew;
    logic [14:0] fnew;
    dir_t      d;
    int        trail [64];
    out_item_t o;
    rows_used = (grid_rows_q > 8) ? 8 : grid_rows_q;
    cols_used = (grid_cols_q > 8) ? 8 : grid_cols_q;
    sr = it.cell_row;
    sc = it.cell_col;
    dr = it.dst_row;
    dc = it.dst_col;
    if (it.func == FUNC_WRITE) begin
      cell_open[sr * 8 + sc] = it.passable;
      return;
    end
    if (!(sr < rows_used && sc < cols_used && dr < rows_used && dc < cols_used)) begin
      push_status(ST_RANGE);
      return;
    end
    if (!cell_open[sr * 8 + sc] || !cell_open[dr * 8 + dc]) begin
      push_status(ST_BLOCKED);
      return;
    end
    if (sr == dr && sc == dc) begin
      push_status(ST_THERE);
      return;
    end
    for (k = 0; k < 64; k++) begin
      cell_closed[k]  = 1'b0;
      cell_reached[k] = 1'b0;
    end
    si = sr * 8 + sc;
    cell_reached[si] = 1'b1;
    cell_f[si] = '0;
    cell_g[si] = '0;
    forever begin
      // pick least (f, row, col) among open-set cells
      best = -1;
      for (r = 0; r < rows_used; r++)
        for (c = 0; c < cols_used; c++) begin
          k = r * 8 + c;
          if (cell_reached[k] && !cell_closed[k] && (best < 0 || cell_f[k] < cell_f[best]))
            best = k;
        end
      if (best < 0) begin
        push_status(ST_NOPATH);
        return;
      end
      cell_closed[best] = 1'b1;
      br = best / 8;
      bc = best % 8;
      for (int di = 0; di < 4; di++) begin
        d  = dir_t'(di);
        nr = br + ((d == DIR_N) ? -1 : (d == DIR_S) ? 1 : 0);
        nc = bc + ((d == DIR_E) ? 1 : (d == DIR_W) ? -1 : 0);
        if (nr < 0 || nr >= rows_used || nc < 0 || nc >= cols_used) continue;
        nk = nr * 8 + nc;
        if (nr == dr && nc == dc) begin
          cell_back[nk] = flip_dir(d);
          // walk back to the source, then emit source first
          n = 0;
          r = dr;
          c = dc;
          while (!(r == sr && c == sc) && n < 63) begin
            trail[n] = r * 8 + c;
            n++;
            if (cell_back[r * 8 + c] == DIR_N) begin
              if (r == 0) break;
              r--;
            end else if (cell_back[r * 8 + c] == DIR_S) begin
              r++;
            end else if (cell_back[r * 8 + c] == DIR_E) begin
              c++;
            end else begin
              if (c == 0) break;
              c--;
            end
            if (r >= 8 || c >= 8) break;
          end
          trail[n] = si;
          n++;
          for (k = 0; k < n; k++) begin
            o.status   = ST_PATH;
            o.path_row = 3'(trail[n - 1 - k] / 8);
            o.path_col = 3'(trail[n - 1 - k] % 8);
            o.last     = (k == n - 1);
            path_expect_q.push_back(o);
          end
          return;
        end
        if (!cell_closed[nk] && cell_open[nk]) begin
          gnew = cell_g[best] + 6'd1;
          fnew = 15'({gnew, 8'd0}) + 15'(dist_q8(nr - dr, nc - dc));
          if (!cell_reached[nk] || cell_f[nk] > fnew) begin
            cell_reached[nk] = 1'b1;
            cell_f[nk]       = fnew;
            cell_g[nk]       = gnew;
            cell_back[nk]    = flip_dir(d);
          end
        end
      end
    end
  endfunction

  // offer one item after a random gap, hold until accepted
  task automatic send_item(in_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    astar_predict(it);
  endtask

  task automatic write_reg(logic idx, logic [3:0] val);
    in_valid <= 1'b0;
    psel     <= 1'b1;
    penable  <= 1'b0;
    pwrite   <= 1'b1;
    paddr    <= (idx == REG_COLS) ? 3'd4 : 3'd0;
    pwdata   <= 32'(val);
    @(posedge clk);
    penable  <= 1'b1;
    @(posedge clk);
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    if (idx == REG_ROWS) grid_rows_q = val;
    else grid_cols_q = val;
  endtask

  // hold the sender until every expected item is out and the block is idle
  task automatic drain();
    in_valid <= 1'b0;
    while (path_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic in_item_t cell_write(int r, int c, logic p);
    in_item_t it;
    it          = in_item_t'($urandom);
    it.func     = FUNC_WRITE;
    it.cell_row = 3'(r);
    it.cell_col = 3'(c);
    it.passable = p;
    return it;
  endfunction

  function automatic in_item_t search(int sr, int sc, int dr, int dc);
    in_item_t it;
    it          = in_item_t'($urandom);
    it.func     = FUNC_SEARCH;
    it.cell_row = 3'(sr);
    it.cell_col = 3'(sc);
    it.dst_row  = 3'(dr);
    it.dst_col  = 3'(dc);
    return it;
  endfunction

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t result;
  } dir_row_t;

  // receiver: random stalls, one long hold-off, compare against predictor
  initial begin
    int gap;
    out_item_t want;
    bit held;
    held      = 1'b0;
    recv_cnt  = 0;
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 11);
      if (recv_cnt == 40 && !held) begin
        held = 1'b1;
        gap  = 600;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      recv_cnt++;
      if (path_expect_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected item: status %0d row %0d col %0d last %0d",
                   out_data.status, out_data.path_row, out_data.path_col, out_data.last);
      end else begin
        want = path_expect_q.pop_front();
        if (out_data.status !== want.status || out_data.path_row !== want.path_row ||
            out_data.path_col !== want.path_col || out_data.last !== want.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("item %0d: expected st %0d (%0d,%0d) last %0d, got st %0d (%0d,%0d) last %0d",
                     recv_cnt, want.status, want.path_row, want.path_col, want.last,
                     out_data.status, out_data.path_row, out_data.path_col, out_data.last);
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // sender
  initial begin
    dir_row_t   rows [$];
    dir_row_t   dr_row;
    out_item_t  o;
    int         rr, cc, sr, sc, tr, tc;
    logic [3:0] cfg_pairs [7][2];
    mismatch_cnt = 0;
    no_idle      = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    grid_rows_q  = 4'd8;
    grid_cols_q  = 4'd8;
    for (int k = 0; k < 64; k++) begin
      cell_open[k] = 1'b0;
      cell_f[k]    = '0;
      cell_g[k]    = '0;
      cell_back[k] = DIR_N;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; typed results for the error cases
    o.path_row = '0;
    o.path_col = '0;
    o.last     = 1'b1;
    o.status = ST_BLOCKED; rows.push_back('{search(0, 0, 7, 7), 1'b1, o});
    rows.push_back('{cell_write(0, 0, 1'b1), 1'b0, o});
    o.status = ST_THERE;   rows.push_back('{search(0, 0, 0, 0), 1'b1, o});
    o.status = ST_BLOCKED; rows.push_back('{search(0, 0, 7, 7), 1'b1, o});
    rows.push_back('{cell_write(0, 1, 1'b1), 1'b0, o});
    rows.push_back('{cell_write(0, 2, 1'b1), 1'b0, o});
    rows.push_back('{cell_write(7, 7, 1'b1), 1'b0, o});
    rows.push_back('{search(0, 0, 0, 2), 1'b0, o});
    rows.push_back('{search(0, 2, 0, 0), 1'b0, o});
    rows.push_back('{search(0, 0, 0, 1), 1'b0, o});
    o.status = ST_NOPATH;  rows.push_back('{search(0, 0, 7, 7), 1'b1, o});
    rows.push_back('{cell_write(0, 1, 1'b0), 1'b0, o});
    o.status = ST_NOPATH;  rows.push_back('{search(0, 0, 0, 2), 1'b1, o});
    o.status = ST_BLOCKED; rows.push_back('{search(7, 7, 0, 1), 1'b1, o});
    o.status = ST_THERE;   rows.push_back('{search(7, 7, 7, 7), 1'b1, o});
    foreach (rows[i]) begin
      dr_row = rows[i];
      send_item(dr_row.item);
      if (dr_row.typed) begin
        // replace the predicted entry by the one typed in the table
        void'(path_expect_q.pop_back());
        path_expect_q.push_back(dr_row.result);
      end
    end
    drain();

    // random phases, each with its own grid size
    cfg_pairs = '{'{4'd8, 4'd8}, '{4'd1, 4'd8}, '{4'd8, 4'd1}, '{4'd0, 4'd5},
                  '{4'd15, 4'd15}, '{4'd3, 4'd4}, '{4'd6, 4'd7}};
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(REG_ROWS, cfg_pairs[ph][0]);
      write_reg(REG_COLS, cfg_pairs[ph][1]);
      no_idle = (ph == 2 || ph == 5);
      rr = (grid_rows_q > 8) ? 8 : (grid_rows_q == 0 ? 1 : grid_rows_q);
      cc = (grid_cols_q > 8) ? 8 : (grid_cols_q == 0 ? 1 : grid_cols_q);
      // open most of the grid in the first phase
      if (ph == 0)
        for (int k = 0; k < 64; k++)
          send_item(cell_write(k / 8, k % 8, $urandom_range(0, 4) != 0));
      for (int n = 0; n < 50; n++) begin
        if ($urandom_range(0, 9) < 3) begin
          send_item(cell_write($urandom_range(0, 7), $urandom_range(0, 7),
                               $urandom_range(0, 4) != 0));
        end else if ($urandom_range(0, 9) < 8) begin
          sr = $urandom_range(0, rr - 1);
          sc = $urandom_range(0, cc - 1);
          tr = $urandom_range(0, rr - 1);
          tc = $urandom_range(0, cc - 1);
          send_item(search(sr, sc, tr, tc));
        end else begin
          send_item(search($urandom_range(0, 7), $urandom_range(0, 7),
                           $urandom_range(0, 7), $urandom_range(0, 7)));
        end
        // pause the sender once until everything is out
        if (ph == 1 && n == 25) drain();
      end
      drain();
    end

    no_idle = 1'b0;
    repeat (50) @(posedge clk);
    if (mismatch_cnt == 0 && path_expect_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
